@@ src/qsu_pkg.sv @@
// shared types, character constants and helpers for the quoted string unescaper
package qsu_pkg;

    typedef enum logic [2:0] {
        MODE_SEEK    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_BODY    = 3'd2,
        MODE_ESCAPE  = 3'd3,
        MODE_HEX     = 3'd4
    } mode_t;

    localparam logic [2:0] ST_DATA   = 3'd0;
    localparam logic [2:0] ST_DONE   = 3'd1;
    localparam logic [2:0] ST_NOTSTR = 3'd2;
    localparam logic [2:0] ST_UNTERM = 3'd3;
    localparam logic [2:0] ST_BADUNI = 3'd4;
    localparam logic [2:0] ST_BADESC = 3'd5;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    // one decoded step: 1 to 3 bytes, or a single status word
    typedef struct packed {
        logic [1:0]      count;
        logic [2:0]      status;
        logic [2:0][7:0] bytes;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // returns {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        return r;
    endfunction

endpackage

@@ src/qsu_if.sv @@
// handshake channels for text input and decoded result words
interface qsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_mark;

    modport source (output valid, output text_byte, output end_mark, input ready);
    modport sink (input valid, input text_byte, input end_mark, output ready);
endinterface

interface qsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output out_byte, output status, output last, input ready);
    modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface

@@ src/qsu_front.sv @@
// front end: scan state machine that classifies each text word into a command
module qsu_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [7:0]         text_byte,
    input  logic               end_mark,
    output logic               cmd_valid,
    output qsu_pkg::cmd_t      cmd
);

    qsu_pkg::mode_t mode_reg, mode_next;
    logic           quote_reg, quote_next;
    logic [1:0]     hex_cnt_reg, hex_cnt_next;
    logic [15:0]    cp_reg, cp_next;

    logic [4:0]  hex_d;
    logic [15:0] cp_shift;
    logic        is_space;
    logic [7:0]  close_quote;

    assign hex_d       = qsu_pkg::hex_value(text_byte);
    assign cp_shift    = {cp_reg[11:0], hex_d[3:0]};
    assign is_space    = (text_byte == qsu_pkg::CH_SPACE) ||
                         (text_byte >= qsu_pkg::CH_TAB && text_byte <= qsu_pkg::CH_CR);
    assign close_quote = quote_reg ? qsu_pkg::CH_DQUOTE : qsu_pkg::CH_SQUOTE;

    // next state
    always_comb
    begin
        mode_next    = mode_reg;
        quote_next   = quote_reg;
        hex_cnt_next = hex_cnt_reg;
        cp_next      = cp_reg;
        if (accept)
        begin
            case (mode_reg)
                qsu_pkg::MODE_COMMENT:
                begin
                    if (end_mark || text_byte == qsu_pkg::CH_LF)
                        mode_next = qsu_pkg::MODE_SEEK;
                    if (end_mark)
                    begin
                        hex_cnt_next = 2'd0;
                        cp_next      = 16'd0;
                    end
                end
                qsu_pkg::MODE_BODY:
                begin
                    if (end_mark || text_byte == close_quote)
                    begin
                        mode_next    = qsu_pkg::MODE_SEEK;
                        hex_cnt_next = 2'd0;
                        cp_next      = 16'd0;
                    end
                    else if (text_byte == qsu_pkg::CH_BSLASH)
                        mode_next = qsu_pkg::MODE_ESCAPE;
                end
                qsu_pkg::MODE_ESCAPE:
                begin
                    if (end_mark)
                    begin
                        mode_next    = qsu_pkg::MODE_SEEK;
                        hex_cnt_next = 2'd0;
                        cp_next      = 16'd0;
                    end
                    else
                    begin
                        case (text_byte)
                            qsu_pkg::CH_DQUOTE, qsu_pkg::CH_SQUOTE, qsu_pkg::CH_BSLASH,
                            qsu_pkg::CH_SLASH, qsu_pkg::CH_LOW_B, qsu_pkg::CH_LOW_F,
                            qsu_pkg::CH_LOW_N, qsu_pkg::CH_LOW_R, qsu_pkg::CH_LOW_T:
                                mode_next = qsu_pkg::MODE_BODY;
                            qsu_pkg::CH_LOW_U:
                            begin
                                mode_next    = qsu_pkg::MODE_HEX;
                                hex_cnt_next = 2'd0;
                                cp_next      = 16'd0;
                            end
                            default:
                            begin
                                mode_next    = qsu_pkg::MODE_SEEK;
                                hex_cnt_next = 2'd0;
                                cp_next      = 16'd0;
                            end
                        endcase
                    end
                end
                qsu_pkg::MODE_HEX:
                begin
                    if (end_mark || !hex_d[4])
                    begin
                        mode_next    = qsu_pkg::MODE_SEEK;
                        hex_cnt_next = 2'd0;
                        cp_next      = 16'd0;
                    end
                    else
                    begin
                        cp_next = cp_shift;
                        if (hex_cnt_reg == 2'd3)
                        begin
                            hex_cnt_next = 2'd0;
                            mode_next    = qsu_pkg::MODE_BODY;
                        end
                        else
                            hex_cnt_next = hex_cnt_reg + 2'd1;
                    end
                end
                default:
                begin
                    mode_next = qsu_pkg::MODE_SEEK;
                    if (end_mark)
                    begin
                        hex_cnt_next = 2'd0;
                        cp_next      = 16'd0;
                    end
                    else if (is_space)
                        mode_next = qsu_pkg::MODE_SEEK;
                    else if (text_byte == qsu_pkg::CH_HASH)
                        mode_next = qsu_pkg::MODE_COMMENT;
                    else if (text_byte == qsu_pkg::CH_SQUOTE ||
                             text_byte == qsu_pkg::CH_DQUOTE)
                    begin
                        quote_next = (text_byte == qsu_pkg::CH_DQUOTE);
                        mode_next  = qsu_pkg::MODE_BODY;
                    end
                    else
                    begin
                        hex_cnt_next = 2'd0;
                        cp_next      = 16'd0;
                    end
                end
            endcase
        end
    end

    // command outputs
    always_comb
    begin
        cmd_valid = 1'b0;
        cmd       = '0;
        cmd.count = 2'd1;
        case (mode_reg)
            qsu_pkg::MODE_COMMENT:
            begin
                if (end_mark)
                begin
                    cmd_valid  = 1'b1;
                    cmd.status = qsu_pkg::ST_NOTSTR;
                end
            end
            qsu_pkg::MODE_BODY:
            begin
                if (end_mark)
                begin
                    cmd_valid  = 1'b1;
                    cmd.status = qsu_pkg::ST_UNTERM;
                end
                else if (text_byte == qsu_pkg::CH_BSLASH)
                    cmd_valid = 1'b0;
                else if (text_byte == close_quote)
                begin
                    cmd_valid  = 1'b1;
                    cmd.status = qsu_pkg::ST_DONE;
                end
                else
                begin
                    cmd_valid    = 1'b1;
                    cmd.bytes[0] = text_byte;
                end
            end
            qsu_pkg::MODE_ESCAPE:
            begin
                cmd_valid = 1'b1;
                if (end_mark)
                    cmd.status = qsu_pkg::ST_UNTERM;
                else
                begin
                    case (text_byte)
                        qsu_pkg::CH_DQUOTE, qsu_pkg::CH_SQUOTE, qsu_pkg::CH_BSLASH,
                        qsu_pkg::CH_SLASH:
                            cmd.bytes[0] = text_byte;
                        qsu_pkg::CH_LOW_B: cmd.bytes[0] = qsu_pkg::CH_BS;
                        qsu_pkg::CH_LOW_F: cmd.bytes[0] = qsu_pkg::CH_FF;
                        qsu_pkg::CH_LOW_N: cmd.bytes[0] = qsu_pkg::CH_LF;
                        qsu_pkg::CH_LOW_R: cmd.bytes[0] = qsu_pkg::CH_CR;
                        qsu_pkg::CH_LOW_T: cmd.bytes[0] = qsu_pkg::CH_TAB;
                        qsu_pkg::CH_LOW_U: cmd_valid = 1'b0;
                        default:           cmd.status = qsu_pkg::ST_BADESC;
                    endcase
                end
            end
            qsu_pkg::MODE_HEX:
            begin
                if (end_mark || !hex_d[4])
                begin
                    cmd_valid  = 1'b1;
                    cmd.status = qsu_pkg::ST_BADUNI;
                end
                else if (hex_cnt_reg == 2'd3)
                begin
                    cmd_valid = 1'b1;
                    // utf-8 encoding of the finished code point
                    if (cp_shift < 16'h0080)
                        cmd.bytes[0] = cp_shift[7:0];
                    else if (cp_shift < 16'h0800)
                    begin
                        cmd.count    = 2'd2;
                        cmd.bytes[0] = {3'b110, cp_shift[10:6]};
                        cmd.bytes[1] = {2'b10, cp_shift[5:0]};
                    end
                    else
                    begin
                        cmd.count    = 2'd3;
                        cmd.bytes[0] = {4'b1110, cp_shift[15:12]};
                        cmd.bytes[1] = {2'b10, cp_shift[11:6]};
                        cmd.bytes[2] = {2'b10, cp_shift[5:0]};
                    end
                end
            end
            default:
            begin
                if (end_mark)
                begin
                    cmd_valid  = 1'b1;
                    cmd.status = qsu_pkg::ST_NOTSTR;
                end
                else if (!is_space && text_byte != qsu_pkg::CH_HASH &&
                         text_byte != qsu_pkg::CH_SQUOTE && text_byte != qsu_pkg::CH_DQUOTE)
                begin
                    cmd_valid  = 1'b1;
                    cmd.status = qsu_pkg::ST_NOTSTR;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= qsu_pkg::MODE_SEEK;
            quote_reg   <= 1'b0;
            hex_cnt_reg <= 2'd0;
            cp_reg      <= 16'd0;
        end
        else
        begin
            mode_reg    <= mode_next;
            quote_reg   <= quote_next;
            hex_cnt_reg <= hex_cnt_next;
            cp_reg      <= cp_next;
        end
    end

endmodule

@@ src/qsu_fifo.sv @@
// short command queue between the front and back ends
module qsu_fifo #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  qsu_pkg::cmd_t        push_cmd,
    input  logic                 pop,
    output qsu_pkg::cmd_t        head,
    output qsu_pkg::fifo_stat_t  stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    qsu_pkg::cmd_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ src/qsu_back.sv @@
// back end: splits commands into result words behind an output register
module qsu_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  qsu_pkg::cmd_t        head,
    input  qsu_pkg::fifo_stat_t  stat,
    output logic                 pop,
    qsu_out_if.source            result
);

    qsu_pkg::cmd_t cmd_reg, cmd_next;
    logic [1:0]    idx_reg, idx_next;
    logic          busy_reg, busy_next;
    logic          valid_reg, valid_next;
    logic [7:0]    byte_reg, byte_next;
    logic [2:0]    status_reg, status_next;
    logic          last_reg, last_next;
    logic          load;

    assign load = !valid_reg || result.ready;
    assign pop  = load && !busy_reg && !stat.empty;

    always_comb
    begin
        cmd_next    = cmd_reg;
        idx_next    = idx_reg;
        busy_next   = busy_reg;
        valid_next  = valid_reg;
        byte_next   = byte_reg;
        status_next = status_reg;
        last_next   = last_reg;
        if (load)
        begin
            if (busy_reg)
            begin
                valid_next  = 1'b1;
                byte_next   = cmd_reg.bytes[idx_reg];
                status_next = qsu_pkg::ST_DATA;
                last_next   = (idx_reg == cmd_reg.count - 2'd1);
                busy_next   = !last_next;
                idx_next    = idx_reg + 2'd1;
            end
            else if (!stat.empty)
            begin
                valid_next  = 1'b1;
                byte_next   = head.bytes[0];
                status_next = head.status;
                last_next   = (head.count == 2'd1);
                busy_next   = !last_next;
                cmd_next    = head;
                idx_next    = 2'd1;
            end
            else
                valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            busy_reg  <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            busy_reg  <= busy_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        byte_reg   <= byte_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign result.valid    = valid_reg;
    assign result.out_byte = byte_reg;
    assign result.status   = status_reg;
    assign result.last     = last_reg;

endmodule

@@ src/quoted_string_unescaper_core.sv @@
// top level of the streaming quoted string unescaper
// usage:
//   text carries one text word per handshake: text_byte, or end_mark for end of text
//   result carries decoded words: out_byte, status (0 data, 1 done, 2 not a string,
//   3 unterminated, 4 bad unicode escape, 5 bad escape) and last on the final word
//   of each input word
// structure:
//   the front end holds the scan state and turns each accepted text word into a
//   command of 0 to 3 result words, pushed into a short queue (FIFO_DEPTH entries)
//   the back end pops commands and, while result.ready is high, issues one result word
//   per cycle from a registered output stage
// timing:
//   one text word is accepted per cycle while the queue has room
//   the command of an accepted text word is queued, then popped into the output register
//   a unicode escape gives up to three result words, one per cycle while result.ready
//   is high, so output bandwidth of one word per cycle sets the sustained rate on such runs
// reset: scanner returns to searching for an opening quote, queue and output empty
// stall: result.ready held low freezes the output stage; the queue fills and then
//   text.ready drops until there is room again
module quoted_string_unescaper_core #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    qsu_in_if.sink    text,
    qsu_out_if.source result
);

    qsu_pkg::cmd_t       front_cmd;
    logic                front_cmd_valid;
    qsu_pkg::cmd_t       fifo_head;
    qsu_pkg::fifo_stat_t fifo_stat;
    logic                accept;
    logic                push;
    logic                pop;

    // input is taken whenever the queue can hold a command
    assign text.ready = !fifo_stat.full;
    assign accept     = text.valid && text.ready;
    // skipped bytes, opening quotes, escape backslashes, the u of an escape and early hex digits push nothing
    assign push       = accept && front_cmd_valid;

    qsu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .text_byte (text.text_byte),
        .end_mark  (text.end_mark),
        .cmd_valid (front_cmd_valid),
        .cmd       (front_cmd)
    );

    qsu_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (front_cmd),
        .pop      (pop),
        .head     (fifo_head),
        .stat     (fifo_stat)
    );

    qsu_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (fifo_head),
        .stat   (fifo_stat),
        .pop    (pop),
        .result (result)
    );

    // no command is pushed into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_stat.full |-> !push)
        else $error("command pushed into full queue");

    // back end never pops an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_stat.empty |-> !pop)
        else $error("command popped from empty queue");

    // status words carry a zero byte and end their input word's results
    a_status_word: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status != qsu_pkg::ST_DATA) |->
        (result.last && result.out_byte == 8'd0))
        else $error("status word with data byte or without last");

endmodule
